// File: src/yuyv_pkg.sv
// Shared constants and types for the YUYV to BGR stream converter.
`default_nettype none
package yuyv_pkg;

	localparam int MAX_WIDTH      = 4096;
	localparam int MAX_HEIGHT     = 4096;
	localparam int MAX_LINE_BYTES = 16384;

	localparam int WIDTH_W    = 13;
	localparam int HEIGHT_W   = 13;
	localparam int LINE_W     = 15;
	localparam int CFG_DATA_W = 15;
	localparam int CFG_IDX_W  = 2;

	localparam logic [WIDTH_W-1:0]  FRAME_WIDTH_RST  = WIDTH_W'(640);
	localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RST = HEIGHT_W'(480);
	localparam logic [LINE_W-1:0]   LINE_BYTES_RST   = LINE_W'(1280);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 2'd0,
		CFG_FRAME_HEIGHT = 2'd1,
		CFG_LINE_BYTES   = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_Y0 = 2'd0,
		PH_U  = 2'd1,
		PH_Y1 = 2'd2,
		PH_V  = 2'd3
	} phase_t;

	// One group (or one error transaction) handed to the output side
	typedef struct packed {
		logic       err;
		logic [7:0] y0;
		logic [7:0] u;
		logic [7:0] y1;
		logic [7:0] v;
		logic       rend;
		logic       fend;
	} job_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pix_t;

endpackage
`default_nettype wire

// File: src/yuyv_to_bgr_stream_core.sv
// Top level of the YUYV 4:2:2 byte stream to BGR888 pixel converter.
//
// Input channel: one raw byte per transaction (in_valid/in_stall, pixel_byte),
// in Y0 U Y1 V order, line by line with line_bytes source bytes per line;
// bytes past 2*frame_width in a line are padding and are dropped.
// Output channel: one pixel per transaction (out_valid/out_stall) with
// blue/green/red and the group_last, row_end, frame_end and config_error flags.
// Every V byte completing a group yields two pixels; with an invalid
// configuration every byte yields one transaction flagged config_error.
// Configuration: cfg_we/cfg_index/cfg_data, written while idle; a write to
// frame width, frame height or line bytes restarts the frame position.
// The first pixel of a group passes the group holding and output registers
// after the V byte is taken, the second follows. Throughput: one byte per
// cycle while in_stall is low; the single output register sends both in turn.
// Reset restores 640x480, 1280 bytes per line, and clears the position.
// When out_stall holds, padding and non-final group bytes are still taken;
// in_stall rises only for a byte that would produce a result while the group
// holding register is busy.
`default_nettype none
module yuyv_to_bgr_stream_core
	import yuyv_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            pixel_byte,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [7:0]                 blue,
	output logic [7:0]                 green,
	output logic [7:0]                 red,
	output logic                       group_last,
	output logic                       row_end,
	output logic                       frame_end,
	output logic                       config_error
);

	job_t job;
	logic job_push;
	logic job_free;

	yuyv_framer u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pixel_byte (pixel_byte),
		.job        (job),
		.job_push   (job_push),
		.job_free   (job_free)
	);

	yuyv_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.job          (job),
		.job_push     (job_push),
		.job_free     (job_free),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.blue         (blue),
		.green        (green),
		.red          (red),
		.group_last   (group_last),
		.row_end      (row_end),
		.frame_end    (frame_end),
		.config_error (config_error)
	);

endmodule
`default_nettype wire

// File: src/yuyv_framer.sv
// Configuration registers, line/frame position tracking and group assembly.
`default_nettype none
module yuyv_framer
	import yuyv_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            pixel_byte,
	output job_t                       job,
	output logic                       job_push,
	input  wire logic                  job_free
);

	logic [WIDTH_W-1:0]  frame_width_q;
	logic [HEIGHT_W-1:0] frame_height_q;
	logic [LINE_W-1:0]   line_bytes_q;

	phase_t              phase_q;
	logic [7:0]          held_y0_q;
	logic [7:0]          held_u_q;
	logic [7:0]          held_y1_q;
	logic [LINE_W-1:0]   lbc_q;
	logic [HEIGHT_W-1:0] lc_q;

	logic                cfg_bad;
	logic [LINE_W-1:0]   data_bytes;
	logic                in_data;
	logic                rend;
	logic                fend;
	logic [LINE_W:0]     lbc_inc;
	logic                line_done;
	logic [HEIGHT_W:0]   lc_inc;
	logic                produce;
	logic                accept;

	assign data_bytes = {1'b0, frame_width_q, 1'b0};

	always_comb begin
		cfg_bad = 1'b0;
		if (frame_width_q == '0 || frame_width_q[0] || 32'(frame_width_q) > MAX_WIDTH)
			cfg_bad = 1'b1;
		if (frame_height_q == '0 || 32'(frame_height_q) > MAX_HEIGHT)
			cfg_bad = 1'b1;
		if (line_bytes_q < data_bytes || 32'(line_bytes_q) > MAX_LINE_BYTES)
			cfg_bad = 1'b1;
	end

	assign in_data   = lbc_q < data_bytes;
	assign rend      = lbc_q == (data_bytes - LINE_W'(1));
	assign fend      = rend && (lc_q == (frame_height_q - HEIGHT_W'(1)));
	assign lbc_inc   = {1'b0, lbc_q} + (LINE_W+1)'(1);
	assign line_done = lbc_inc >= {1'b0, line_bytes_q};
	assign lc_inc    = {1'b0, lc_q} + (HEIGHT_W+1)'(1);

	assign produce  = cfg_bad || (in_data && phase_q == PH_V);
	assign in_stall = produce && !job_free;
	assign accept   = in_valid && !in_stall;
	assign job_push = accept && produce;

	always_comb begin
		job.err  = cfg_bad;
		job.y0   = held_y0_q;
		job.u    = held_u_q;
		job.y1   = held_y1_q;
		job.v    = pixel_byte;
		job.rend = rend;
		job.fend = fend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			line_bytes_q   <= LINE_BYTES_RST;
			phase_q        <= PH_Y0;
			lbc_q          <= '0;
			lc_q           <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_FRAME_WIDTH: begin
					frame_width_q <= cfg_data[WIDTH_W-1:0];
					phase_q       <= PH_Y0;
					lbc_q         <= '0;
					lc_q          <= '0;
				end
				CFG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data[HEIGHT_W-1:0];
					phase_q        <= PH_Y0;
					lbc_q          <= '0;
					lc_q           <= '0;
				end
				CFG_LINE_BYTES: begin
					line_bytes_q <= cfg_data[LINE_W-1:0];
					phase_q      <= PH_Y0;
					lbc_q        <= '0;
					lc_q         <= '0;
				end
				default: begin
				end
			endcase
		end else if (accept && !cfg_bad) begin
			if (line_done) begin
				phase_q <= PH_Y0;
				lbc_q   <= '0;
				if (lc_inc >= {1'b0, frame_height_q})
					lc_q <= '0;
				else
					lc_q <= lc_inc[HEIGHT_W-1:0];
			end else begin
				lbc_q <= lbc_inc[LINE_W-1:0];
				if (in_data)
					phase_q <= phase_t'(phase_q + 2'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !cfg_bad && in_data) begin
			case (phase_q)
				PH_Y0:   held_y0_q <= pixel_byte;
				PH_U:    held_u_q  <= pixel_byte;
				PH_Y1:   held_y1_q <= pixel_byte;
				default: begin
				end
			endcase
		end
	end

	a_bad_cfg_holds_pos: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cfg_bad && !cfg_we |=> lbc_q == $past(lbc_q) && lc_q == $past(lc_q))
		else $error("position advanced under invalid configuration");

	a_pos_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_bad |-> lbc_q < line_bytes_q && lc_q < frame_height_q)
		else $error("line position out of range");

	a_padding_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_bad && !in_data |-> phase_q == PH_Y0)
		else $error("group phase not aligned at padding");

endmodule
`default_nettype wire

// File: src/yuyv_convert.sv
// YUV to BGR conversion of one pixel with chroma offsets and clamping.
`default_nettype none
module yuyv_convert
	import yuyv_pkg::*;
(
	input  wire logic [7:0] y,
	input  wire logic [7:0] u,
	input  wire logic [7:0] v,
	output pix_t            pix
);

	logic signed [8:0]  uc;
	logic signed [8:0]  vc;
	logic signed [17:0] r_prod;
	logic signed [17:0] g_prod;
	logic signed [17:0] b_prod;
	logic signed [17:0] r_shr;
	logic signed [17:0] g_shr;
	logic signed [17:0] b_shr;
	logic signed [10:0] ys;
	logic signed [10:0] r_sum;
	logic signed [10:0] g_sum;
	logic signed [10:0] b_sum;

	function automatic logic [7:0] clamp8(input logic signed [10:0] x);
		logic [7:0] r;
		if (x < 0)
			r = 8'd0;
		else if (x > 11'sd255)
			r = 8'd255;
		else
			r = x[7:0];
		return r;
	endfunction

	assign uc = $signed({1'b0, u}) - 9'sd128;
	assign vc = $signed({1'b0, v}) - 9'sd128;

	assign r_prod = 18'sd359 * 18'(vc);
	assign g_prod = -(18'sd88 * 18'(uc)) - 18'sd183 * 18'(vc);
	assign b_prod = 18'sd454 * 18'(uc);

	// arithmetic shift gives floor division by 256
	assign r_shr = r_prod >>> 8;
	assign g_shr = g_prod >>> 8;
	assign b_shr = b_prod >>> 8;

	assign ys    = $signed({3'b000, y});
	assign r_sum = ys + $signed(r_shr[10:0]);
	assign g_sum = ys + $signed(g_shr[10:0]);
	assign b_sum = ys + $signed(b_shr[10:0]);

	always_comb begin
		pix.red   = clamp8(r_sum);
		pix.green = clamp8(g_sum);
		pix.blue  = clamp8(b_sum);
	end

endmodule
`default_nettype wire

// File: src/yuyv_outq.sv
// Group holding and output registers sending a group's two pixels, or one error item.
`default_nettype none
module yuyv_outq
	import yuyv_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire job_t job,
	input  wire logic job_push,
	output logic      job_free,
	output logic      out_valid,
	input  wire logic out_stall,
	output logic [7:0] blue,
	output logic [7:0] green,
	output logic [7:0] red,
	output logic      group_last,
	output logic      row_end,
	output logic      frame_end,
	output logic      config_error
);

	job_t       job_s1;
	logic       valid_s1;
	logic       idx_s1;
	logic       load_ok;
	logic       emit;
	logic       last;
	logic [7:0] y_sel;
	pix_t       pix;

	assign load_ok  = !out_valid || !out_stall;
	assign emit     = valid_s1 && load_ok;
	assign last     = job_s1.err || idx_s1;
	assign job_free = !valid_s1 || (load_ok && last);
	assign y_sel    = idx_s1 ? job_s1.y1 : job_s1.y0;

	yuyv_convert u_convert (
		.y   (y_sel),
		.u   (job_s1.u),
		.v   (job_s1.v),
		.pix (pix)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			idx_s1    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (job_push) begin
				valid_s1 <= 1'b1;
				idx_s1   <= 1'b0;
			end else if (emit) begin
				if (last) begin
					valid_s1 <= 1'b0;
					idx_s1   <= 1'b0;
				end else begin
					idx_s1 <= 1'b1;
				end
			end
			if (emit)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_push)
			job_s1 <= job;
		if (emit) begin
			if (job_s1.err) begin
				blue         <= 8'd0;
				green        <= 8'd0;
				red          <= 8'd0;
				group_last   <= 1'b0;
				row_end      <= 1'b0;
				frame_end    <= 1'b0;
				config_error <= 1'b1;
			end else begin
				blue         <= pix.blue;
				green        <= pix.green;
				red          <= pix.red;
				group_last   <= idx_s1;
				row_end      <= idx_s1 && job_s1.rend;
				frame_end    <= idx_s1 && job_s1.fend;
				config_error <= 1'b0;
			end
		end
	end

	a_push_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> job_free)
		else $error("group pushed into a busy holding register");

	a_second_pixel_valid: assert property (@(posedge clk) disable iff (!arst_n)
		idx_s1 |-> valid_s1 && !job_s1.err)
		else $error("second pixel pending without a valid group");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && config_error |-> blue == 8'd0 && green == 8'd0 && red == 8'd0
			&& !group_last && !row_end && !frame_end)
		else $error("error transaction carries pixel data");

	a_frame_end_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> row_end && group_last)
		else $error("frame end without row end on second pixel");

endmodule
`default_nettype wire

// File: tb/yuyv_to_bgr_stream_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for yuyv_to_bgr_stream_core: random formats and bytes vs. a local model.
module yuyv_to_bgr_stream_core_tb;
	import yuyv_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int TIMEOUT_NS   = 400_000;
	localparam int RANDOM_ITEMS = 450;

	typedef struct {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       last;
		logic       rend;
		logic       fend;
		logic       err;
	} bgr_pixel_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  in_valid     = 1'b0;
	logic                  in_stall;
	logic [7:0]            pixel_byte   = '0;
	logic                  out_valid;
	logic                  out_stall    = 1'b0;
	logic [7:0]            blue;
	logic [7:0]            green;
	logic [7:0]            red;
	logic                  group_last;
	logic                  row_end;
	logic                  frame_end;
	logic                  config_error;

	// model of the converter
	int     fmt_width  = 640;
	int     fmt_height = 480;
	int     fmt_pitch  = 1280;
	phase_t grp_phase  = PH_Y0;
	logic [7:0] hold_y0 = '0;
	logic [7:0] hold_u  = '0;
	logic [7:0] hold_y1 = '0;
	int     col_byte   = 0;
	int     row_idx    = 0;

	logic [7:0] bytes_todo[$];
	bgr_pixel_t pixels_due[$];
	bgr_pixel_t head_px;

	int errors       = 0;
	int bytes_taken  = 0;
	int pixels_seen  = 0;
	int formats_used = 0;
	int reg_writes   = 0;
	int random_bytes = 0;
	int gap_pct      = 7;
	int stall_pct    = 7;

	yuyv_to_bgr_stream_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pixel_byte   (pixel_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.blue         (blue),
		.green        (green),
		.red          (red),
		.group_last   (group_last),
		.row_end      (row_end),
		.frame_end    (frame_end),
		.config_error (config_error)
	);

	always #2 clk = ~clk;

	function automatic logic [7:0] clamp_u8(input int x);
		if (x < 0)
			return 8'd0;
		if (x > 255)
			return 8'd255;
		return 8'(x);
	endfunction

	function automatic bit format_ok();
		if (fmt_width == 0 || fmt_width[0] || fmt_width > MAX_WIDTH)
			return 1'b0;
		if (fmt_height == 0 || fmt_height > MAX_HEIGHT)
			return 1'b0;
		if (fmt_pitch < 2 * fmt_width || fmt_pitch > MAX_LINE_BYTES)
			return 1'b0;
		return 1'b1;
	endfunction

	function automatic bgr_pixel_t make_pixel(input logic [7:0] y, input int bo, input int go,
			input int ro, input logic last, input logic rend, input logic fend);
		bgr_pixel_t p;
		p.blue  = clamp_u8(int'(y) + bo);
		p.green = clamp_u8(int'(y) + go);
		p.red   = clamp_u8(int'(y) + ro);
		p.last  = last;
		p.rend  = rend;
		p.fend  = fend;
		p.err   = 1'b0;
		return p;
	endfunction

	task automatic convert_byte(input logic [7:0] b);
		bgr_pixel_t p;
		int u, v, ro, go, bo, data_bytes;
		logic rend, fend;
		if (!format_ok()) begin
			p = '{default: '0};
			p.err = 1'b1;
			pixels_due.push_back(p);
			return;
		end
		data_bytes = 2 * fmt_width;
		if (col_byte < data_bytes) begin
			case (grp_phase)
				PH_Y0: hold_y0 = b;
				PH_U:  hold_u  = b;
				PH_Y1: hold_y1 = b;
				PH_V: begin
					u  = int'(hold_u) - 128;
					v  = int'(b) - 128;
					ro = (359 * v) >>> 8;
					go = (-88 * u - 183 * v) >>> 8;
					bo = (454 * u) >>> 8;
					rend = (col_byte == data_bytes - 1);
					fend = rend && (row_idx == fmt_height - 1);
					pixels_due.push_back(make_pixel(hold_y0, bo, go, ro, 1'b0, 1'b0, 1'b0));
					pixels_due.push_back(make_pixel(hold_y1, bo, go, ro, 1'b1, rend, fend));
				end
				default: ;
			endcase
			grp_phase = phase_t'(grp_phase + 2'd1);
		end
		col_byte++;
		if (col_byte >= fmt_pitch) begin
			col_byte  = 0;
			grp_phase = PH_Y0;
			row_idx++;
			if (row_idx >= fmt_height)
				row_idx = 0;
		end
	endtask

	// byte driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			pixel_byte <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				convert_byte(pixel_byte);
				bytes_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (bytes_todo.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
					in_valid   <= 1'b1;
					pixel_byte <= bytes_todo.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// pixel monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pixels_due.size() == 0) begin
					$error("pixel transaction with nothing pending");
					errors++;
				end else begin
					head_px = pixels_due.pop_front();
					check_field("blue", head_px.blue, blue);
					check_field("green", head_px.green, green);
					check_field("red", head_px.red, red);
					check_field("group_last", head_px.last, group_last);
					check_field("row_end", head_px.rend, row_end);
					check_field("frame_end", head_px.fend, frame_end);
					check_field("config_error", head_px.err, config_error);
					pixels_seen++;
				end
			end
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic settle();
		do
			@(posedge clk);
		while (bytes_todo.size() != 0 || in_valid || pixels_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		logic [CFG_DATA_W-1:0] data;
		data = CFG_DATA_W'(val);
		// upper bits are dropped by the 13-bit registers
		if (idx == CFG_FRAME_WIDTH || idx == CFG_FRAME_HEIGHT)
			data[14:13] = 2'($urandom_range(0, 3));
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			CFG_FRAME_WIDTH:  fmt_width  = int'(data[12:0]);
			CFG_FRAME_HEIGHT: fmt_height = int'(data[12:0]);
			CFG_LINE_BYTES:   fmt_pitch  = int'(data);
			default: ;
		endcase
		if (idx != CFG_UNUSED) begin
			grp_phase = PH_Y0;
			col_byte  = 0;
			row_idx   = 0;
		end
		reg_writes++;
	endtask

	task automatic set_format(input int w, input int h, input int lb);
		settle();
		write_reg(CFG_FRAME_WIDTH, w);
		write_reg(CFG_FRAME_HEIGHT, h);
		write_reg(CFG_LINE_BYTES, lb);
		@(posedge clk);
		cfg_we <= 1'b0;
		formats_used++;
	endtask

	task automatic queue_bytes(input int n);
		repeat (n) bytes_todo.push_back(8'($urandom_range(0, 255)));
	endtask

	initial begin
		logic [7:0] groups [24];
		int kind, w, h, lb, n, phase_no;
		groups = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255,
			8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255,
			8'd128, 8'd128, 8'd128, 8'd128, 8'd200, 8'd64, 8'd50, 8'd192};
		phase_no = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset format, chroma and luma extremes
		foreach (groups[i])
			bytes_todo.push_back(groups[i]);
		// odd width: every byte flagged
		set_format(3, 480, 1280);
		queue_bytes(2);
		// smallest frame: one group per line, one line per frame
		set_format(2, 1, 4);
		queue_bytes(8);

		while (random_bytes < RANDOM_ITEMS) begin
			phase_no++;
			if (phase_no >= 12 && phase_no < 20) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else begin
				gap_pct   = 7;
				stall_pct = 7;
			end
			kind = $urandom_range(0, 9);
			case (kind)
				6: begin
					w  = 2 * $urandom_range(1, 8);
					h  = $urandom_range(1, 4);
					lb = 2 * w + $urandom_range(0, 3);
					case ($urandom_range(0, 6))
						0: w  = 0;
						1: w  = $urandom_range(0, 8191) | 1;
						2: h  = 0;
						3: lb = $urandom_range(0, 2 * w - 1);
						4: w  = 4098 + 2 * $urandom_range(0, 2046);
						5: h  = $urandom_range(4097, 8191);
						default: lb = $urandom_range(16385, 32767);
					endcase
					n = $urandom_range(5, 12);
				end
				7: begin
					w  = 2 * $urandom_range(100, 2048);
					h  = $urandom_range(1, 4096);
					lb = $urandom_range(2 * w, 16384);
					n  = $urandom_range(16, 40);
				end
				8: begin
					w  = 4096;
					h  = 4096;
					lb = 16384;
					n  = 20;
				end
				9: begin
					w  = 2;
					h  = 1;
					lb = 4;
					n  = 4 * $urandom_range(3, 8) + $urandom_range(0, 3);
				end
				default: begin
					w  = 2 * $urandom_range(1, 4);
					h  = $urandom_range(1, 3);
					lb = 2 * w + $urandom_range(0, 3);
					n  = lb * h * $urandom_range(1, 2) + $urandom_range(0, 3);
				end
			endcase
			set_format(w, h, lb);
			queue_bytes(n);
			random_bytes += n;
			// unused index must leave the frame position alone
			if (kind <= 5 && $urandom_range(0, 3) == 0) begin
				settle();
				write_reg(CFG_UNUSED, $urandom_range(0, 32767));
				@(posedge clk);
				cfg_we <= 1'b0;
				n = $urandom_range(4, 20);
				queue_bytes(n);
				random_bytes += n;
			end
		end
		settle();

		$display("Sent %0d bytes over %0d formats with %0d register writes; %0d pixels checked.",
			bytes_taken, formats_used, reg_writes, pixels_seen);
		$display("Formats ranged from invalid and minimal to padded lines and full size.");
		if (errors == 0)
			$display("[yuyv_to_bgr_stream_core] OK");
		else
			$display("[yuyv_to_bgr_stream_core] ERROR");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("[yuyv_to_bgr_stream_core] ERROR");
		$finish;
	end

endmodule

// File: filelist.f
src/yuyv_pkg.sv
src/yuyv_framer.sv
src/yuyv_convert.sv
src/yuyv_outq.sv
src/yuyv_to_bgr_stream_core.sv
tb/yuyv_to_bgr_stream_core_tb.sv
